>>> src/assert_macros.svh
// Assertion macros shared by the parser RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/ipv4tp_pkg.sv
// Types and constants for the dotted IPv4 text address parser.
// No dependencies.
`default_nettype none

package ipv4tp_pkg;

    typedef enum logic [2:0] {
        TK_DEC,
        TK_HEX,
        TK_X,
        TK_DOT,
        TK_WS,
        TK_NUL,
        TK_OTHER
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] val;
    } token_t;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_ZERO   = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_FAIL   = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_OCT,
        RX_HEX
    } radix_t;

    localparam logic [31:0] LIM_ONE_EARLIER   = 32'h00ff_ffff;
    localparam logic [31:0] LIM_TWO_EARLIER   = 32'h0000_ffff;
    localparam logic [31:0] LIM_THREE_EARLIER = 32'h0000_00ff;
    localparam logic [1:0]  MAX_EARLIER       = 2'd3;

endpackage

`default_nettype wire

>>> src/ipv4tp_front.sv
// Front end: accepts characters and classifies them into tokens.
// Depends on ipv4tp_pkg.
`default_nettype none

module ipv4tp_front (
    input  wire logic [7:0]         character,
    input  wire logic               push,
    input  wire logic               q_full,
    output logic                    q_wr,
    output ipv4tp_pkg::token_t      q_tok
);
    import ipv4tp_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [3:0] HEX_BIAS  = 4'd9;

    assign q_wr = push && !q_full;

    always_comb
    begin
        q_tok.kind = TK_OTHER;
        q_tok.val  = '0;
        if (character >= CH_ZERO && character <= CH_NINE)
        begin
            q_tok.kind = TK_DEC;
            q_tok.val  = character[3:0];
        end
        else if ((character >= CH_LO_A && character <= CH_LO_F) ||
                 (character >= CH_UP_A && character <= CH_UP_F))
        begin
            // low nibble of a..f is 1..6
            q_tok.kind = TK_HEX;
            q_tok.val  = character[3:0] + HEX_BIAS;
        end
        else if (character == CH_LO_X || character == CH_UP_X)
        begin
            q_tok.kind = TK_X;
        end
        else if (character == CH_DOT)
        begin
            q_tok.kind = TK_DOT;
        end
        else if (character == CH_SPACE || (character >= CH_TAB && character <= CH_CR))
        begin
            q_tok.kind = TK_WS;
        end
        else if (character == CH_NUL)
        begin
            q_tok.kind = TK_NUL;
        end
    end

endmodule

`default_nettype wire

>>> src/ipv4tp_queue.sv
// Token queue between the classifier and the parser core.
// Depends on ipv4tp_pkg and assert_macros.svh.
`default_nettype none

module ipv4tp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr,
    input  wire ipv4tp_pkg::token_t  wr_data,
    input  wire logic                rd,
    output ipv4tp_pkg::token_t       rd_data,
    output logic                     full,
    output logic                     empty
);
    import ipv4tp_pkg::*;
    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    token_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full    = count_reg == CNT_FULL;
    assign empty   = count_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CNT_FULL)
    `ASSERT_NEVER(a_rd_when_empty, clk, rst_n, rd && count_reg == '0)
    `ASSERT_NEVER(a_wr_when_full, clk, rst_n, wr && !rd && count_reg == CNT_FULL)

endmodule

`default_nettype wire

>>> src/ipv4tp_back.sv
// Parser core: runs the address grammar on tokens and holds the result beat.
// Depends on ipv4tp_pkg and assert_macros.svh.
`default_nettype none

module ipv4tp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ipv4tp_pkg::token_t  tok,
    input  wire logic                tok_avail,
    output logic                     tok_take,
    output logic                     empty,
    input  wire logic                pop,
    output logic                     valid_res,
    output logic [31:0]              address
);
    import ipv4tp_pkg::*;
    `include "assert_macros.svh"

    phase_t       phase_reg, phase_next;
    radix_t       radix_reg, radix_next;
    logic [31:0]  part_reg, part_next;
    logic [1:0]   parts_done_reg, parts_done_next;
    logic         early_bad_reg, early_bad_next;
    logic [32:0]  held_reg, held_next;
    logic [7:0]   early_byte_reg [3];
    logic         byte_wr;

    logic         out_valid_reg, out_valid_next;
    logic         res_valid_reg;
    logic [31:0]  res_addr_reg;

    logic         slot_free;
    logic         take_nul;
    radix_t       eff_radix;
    logic [31:0]  acc;
    logic [32:0]  finish;
    logic [32:0]  nul_result;

    assign slot_free = !out_valid_reg || pop;
    assign tok_take  = tok_avail && (tok.kind != TK_NUL || slot_free);
    assign take_nul  = tok_take && tok.kind == TK_NUL;
    assign eff_radix = (phase_reg == PH_ZERO) ? RX_OCT : radix_reg;

    always_comb
    begin
        case (eff_radix)
            RX_HEX:  acc = {part_reg[27:0], 4'b0} + {28'b0, tok.val};
            RX_OCT:  acc = {part_reg[28:0], 3'b0} + {28'b0, tok.val};
            default: acc = {part_reg[28:0], 3'b0} + {part_reg[30:0], 1'b0}
                           + {28'b0, tok.val};
        endcase
    end

    always_comb
    begin
        case (parts_done_reg)
            2'd0:
                finish = {1'b1, part_reg};
            2'd1:
                finish = (part_reg > LIM_ONE_EARLIER || early_bad_reg) ? '0 :
                         {1'b1, early_byte_reg[0], part_reg[23:0]};
            2'd2:
                finish = (part_reg > LIM_TWO_EARLIER || early_bad_reg) ? '0 :
                         {1'b1, early_byte_reg[0], early_byte_reg[1], part_reg[15:0]};
            default:
                finish = (part_reg > LIM_THREE_EARLIER || early_bad_reg) ? '0 :
                         {1'b1, early_byte_reg[0], early_byte_reg[1],
                          early_byte_reg[2], part_reg[7:0]};
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            PH_ZERO, PH_DIGITS: nul_result = finish;
            PH_DONE:            nul_result = held_reg;
            default:            nul_result = '0;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        radix_next      = radix_reg;
        part_next       = part_reg;
        parts_done_next = parts_done_reg;
        early_bad_next  = early_bad_reg;
        held_next       = held_reg;
        byte_wr         = 1'b0;
        if (take_nul)
        begin
            phase_next      = PH_START;
            radix_next      = RX_DEC;
            part_next       = '0;
            parts_done_next = '0;
            early_bad_next  = 1'b0;
            held_next       = '0;
        end
        else if (tok_take)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (tok.kind != TK_DEC)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (tok.val == 4'd0)
                    begin
                        phase_next = PH_ZERO;
                        part_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_DIGITS;
                        radix_next = RX_DEC;
                        part_next  = {28'b0, tok.val};
                    end
                end
                PH_ZERO, PH_DIGITS:
                begin
                    phase_next = PH_DIGITS;
                    radix_next = eff_radix;
                    if (phase_reg == PH_ZERO && tok.kind == TK_X)
                    begin
                        radix_next = RX_HEX;
                    end
                    else if (tok.kind == TK_DEC ||
                             (tok.kind == TK_HEX && eff_radix == RX_HEX))
                    begin
                        part_next = acc;
                    end
                    else if (tok.kind == TK_DOT)
                    begin
                        if (parts_done_reg == MAX_EARLIER)
                        begin
                            phase_next = PH_FAIL;
                        end
                        else
                        begin
                            byte_wr         = 1'b1;
                            early_bad_next  = early_bad_reg || (|part_reg[31:8]);
                            parts_done_next = parts_done_reg + 1'b1;
                            part_next       = '0;
                            radix_next      = RX_DEC;
                            phase_next      = PH_START;
                        end
                    end
                    else if (tok.kind == TK_WS)
                    begin
                        held_next  = finish;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take_nul)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            radix_reg      <= RX_DEC;
            part_reg       <= '0;
            parts_done_reg <= '0;
            early_bad_reg  <= 1'b0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            radix_reg      <= radix_next;
            part_reg       <= part_next;
            parts_done_reg <= parts_done_next;
            early_bad_reg  <= early_bad_next;
            held_reg       <= held_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_wr)
        begin
            early_byte_reg[parts_done_reg] <= part_reg[7:0];
        end
        if (take_nul)
        begin
            res_valid_reg <= nul_result[32];
            res_addr_reg  <= nul_result[31:0];
        end
    end

    assign empty     = !out_valid_reg;
    assign valid_res = res_valid_reg;
    assign address   = res_addr_reg;

    `ASSERT_NEXT(a_restart, clk, rst_n, take_nul, phase_reg == PH_START && parts_done_reg == '0)
    `ASSERT_IMPLIES(a_zero_on_fail, clk, rst_n, out_valid_reg && !res_valid_reg, res_addr_reg == '0)
    `ASSERT_NEVER(a_nul_overrun, clk, rst_n, take_nul && out_valid_reg && !pop)

endmodule

`default_nettype wire

>>> src/ipv4_text_address_parser.sv
// Dotted IPv4 text address parser: character stream in, one result per string.
// Depends on ipv4tp_pkg, ipv4tp_front, ipv4tp_queue and ipv4tp_back.
//
// Input channel: one character per beat, accepted when push is high and full
// is low. NUL (0) ends a string. Output channel: one beat per string (valid
// flag and address), shown while empty is low and taken when pop is high.
// The front classifies each character into a token and writes it into a
// QUEUE_DEPTH-entry token queue; the parser core takes one token per cycle
// unless a NUL waits for the output register. Throughput is one character
// per cycle while full is low. A result is registered when its NUL leaves
// the queue. The result sits in one output register; a new NUL waits in the
// queue until that register is popped, and characters after it queue behind.
// When the receiver stalls with a result held, the next NUL waits at the head
// of the queue, and full rises once QUEUE_DEPTH-1 characters queue behind it.
// Reset clears the queue, the output valid flag and the parser state; the block
// takes characters at once after.
`default_nettype none

module ipv4_text_address_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   character,
    output logic              empty,
    input  wire logic         pop,
    output logic              valid_res,
    output logic [31:0]       address
);
    import ipv4tp_pkg::*;

    logic    q_wr;
    token_t  q_wr_tok;
    token_t  q_rd_tok;
    logic    q_empty;
    logic    q_rd;

    ipv4tp_front u_front (
        .character (character),
        .push      (push),
        .q_full    (full),
        .q_wr      (q_wr),
        .q_tok     (q_wr_tok)
    );

    ipv4tp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_tok),
        .rd      (q_rd),
        .rd_data (q_rd_tok),
        .full    (full),
        .empty   (q_empty)
    );

    ipv4tp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (q_rd_tok),
        .tok_avail (!q_empty),
        .tok_take  (q_rd),
        .empty     (empty),
        .pop       (pop),
        .valid_res (valid_res),
        .address   (address)
    );

endmodule

`default_nettype wire

>>> tb/ipv4_text_address_parser_test.sv
// Testbench for ipv4_text_address_parser: drives text strings one character per beat
// and checks each result against a scoreboard that parses the same characters itself.
// Depends on ipv4tp_pkg and the parser RTL.
module ipv4_text_address_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4tp_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int END_SETTLE  = 20;

    class ipv4_parse_scoreboard;
        phase_t      mode;
        radix_t      base;
        logic [31:0] acc;
        logic [1:0]  closed;
        logic [31:0] closed_parts [3];
        logic [32:0] latched;
        logic [32:0] due_q [$];
        int          errors;

        function new();
            errors = 0;
            foreach (closed_parts[i])
                closed_parts[i] = '0;
            restart();
        endfunction

        function void restart();
            mode    = PH_START;
            base    = RX_DEC;
            acc     = '0;
            closed  = '0;
            latched = '0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_space(logic [7:0] c);
            return c == " " || (c >= 8'h09 && c <= 8'h0d);
        endfunction

        function int hex_digit(logic [7:0] c);
            if (is_digit(c))
                return c - "0";
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            return -1;
        endfunction

        // bit 32 is the valid flag
        function logic [32:0] assemble();
            logic [31:0] v;
            logic [31:0] lim;
            v = acc;
            if (closed == 2'd0)
                return {1'b1, v};
            lim = (closed == 2'd1) ? LIM_ONE_EARLIER :
                  (closed == 2'd2) ? LIM_TWO_EARLIER : LIM_THREE_EARLIER;
            if (v > lim)
                return '0;
            for (int i = 0; i < closed; i++)
            begin
                if (closed_parts[i] > LIM_THREE_EARLIER)
                    return '0;
                v |= closed_parts[i] << (24 - 8 * i);
            end
            return {1'b1, v};
        endfunction

        function void absorb_char(logic [7:0] c);
            logic [32:0] r;
            logic [31:0] mult;
            bit          was_zero;
            if (c == 8'h00)
            begin
                r = '0;
                if (mode == PH_ZERO || mode == PH_DIGITS)
                    r = assemble();
                else if (mode == PH_DONE)
                    r = latched;
                due_q.push_back(r);
                restart();
                return;
            end
            case (mode)
                PH_START:
                begin
                    if (!is_digit(c))
                        mode = PH_FAIL;
                    else
                    begin
                        acc = '0;
                        if (c == "0")
                            mode = PH_ZERO;
                        else
                        begin
                            base = RX_DEC;
                            acc  = 32'(c - "0");
                            mode = PH_DIGITS;
                        end
                    end
                end
                PH_ZERO, PH_DIGITS:
                begin
                    was_zero = (mode == PH_ZERO);
                    mode = PH_DIGITS;
                    if (was_zero && (c == "x" || c == "X"))
                        base = RX_HEX;
                    else
                    begin
                        if (was_zero)
                            base = RX_OCT;
                        mult = (base == RX_HEX) ? 32'd16 : (base == RX_OCT) ? 32'd8 : 32'd10;
                        if (is_digit(c))
                            acc = acc * mult + 32'(c - "0");
                        else if (base == RX_HEX && hex_digit(c) >= 0)
                            acc = (acc << 4) | 32'(hex_digit(c));
                        else if (c == ".")
                        begin
                            if (closed == MAX_EARLIER)
                                mode = PH_FAIL;
                            else
                            begin
                                closed_parts[closed] = acc;
                                closed++;
                                acc  = '0;
                                base = RX_DEC;
                                mode = PH_START;
                            end
                        end
                        else if (is_space(c))
                        begin
                            latched = assemble();
                            mode = PH_DONE;
                        end
                        else
                            mode = PH_FAIL;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void check_result(logic valid_got, logic [31:0] addr_got);
            logic [32:0] want;
            if (due_q.size() == 0)
            begin
                $display("%0t: unexpected result beat valid_res=%0b address=%h",
                         $time, valid_got, addr_got);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (valid_got !== want[32])
            begin
                $display("%0t: valid_res expected %0b actual %0b", $time, want[32], valid_got);
                errors++;
            end
            if (addr_got !== want[31:0])
            begin
                $display("%0t: address expected %h actual %h", $time, want[31:0], addr_got);
                errors++;
            end
        endfunction

        function int due_count();
            return due_q.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        pop       = 1'b0;
    logic [7:0]  character = 8'h00;
    logic        full;
    logic        empty;
    logic        valid_res;
    logic [31:0] address;

    ipv4_parse_scoreboard sb;
    logic [7:0] text_q [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent_chars    = 0;
    int quiet_cycles  = 0;

    ipv4_text_address_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .character (character),
        .empty     (empty),
        .pop       (pop),
        .valid_res (valid_res),
        .address   (address)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.absorb_char(character);
            if (pop && !empty)
                sb.check_result(valid_res, address);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        bit taken;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if ($urandom_range(99) < send_idle_pct)
                push <= 1'b0;
            else
            begin
                push      <= 1'b1;
                character <= c;
                @(posedge clk);
                taken = !full;
            end
        end
        sent_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(8'h00);
    endtask

    task automatic send_queued();
        foreach (text_q[i])
            send_char(text_q[i]);
        text_q.delete();
    endtask

    // sender holds off until every outstanding result has been popped
    task automatic drain_results();
        @(negedge clk);
        push <= 1'b0;
        while (sb.due_count() != 0)
            @(posedge clk);
    endtask

    task automatic put_digits(logic [31:0] v, int unsigned b, bit upper);
        logic [7:0]  digs [$];
        int unsigned r;
        do
        begin
            r = v % b;
            digs.push_front(r < 10 ? 8'("0" + r) : 8'((upper ? "A" : "a") + r - 10));
            v = v / b;
        end
        while (v != 0);
        foreach (digs[k])
            text_q.push_back(digs[k]);
    endtask

    function automatic logic [31:0] pick_value(bit is_last, int nparts);
        logic [31:0] lim;
        int          sel;
        sel = $urandom_range(99);
        if (!is_last)
        begin
            if (sel < 85)
                return $urandom_range(255);
            if (sel < 93)
                return 32'hff;
            return $urandom_range(1000, 256);
        end
        lim = (nparts == 1) ? 32'hffff_ffff : (nparts == 2) ? LIM_ONE_EARLIER :
              (nparts == 3) ? LIM_TWO_EARLIER : LIM_THREE_EARLIER;
        if (sel < 25)
            return $urandom_range(lim);
        if (sel < 40)
            return lim;
        if (sel < 50)
            return lim + 1;
        if (sel < 60)
            return $urandom;
        return $urandom_range(255);
    endfunction

    task automatic put_part(logic [31:0] v);
        int sel;
        sel = $urandom_range(19);
        if (sel < 10)
            put_digits(v, 10, 1'b0);
        else if (sel < 13)
        begin
            text_q.push_back("0");
            if (v != 0)
                put_digits(v, 8, 1'b0);
        end
        else if (sel < 17)
        begin
            text_q.push_back("0");
            text_q.push_back($urandom_range(1) ? "x" : "X");
            if (v != 0 || $urandom_range(1))
                put_digits(v, 16, $urandom_range(1));
        end
        else if (sel == 17)
        begin
            // octal with 8 and 9 mixed in
            text_q.push_back("0");
            repeat ($urandom_range(4, 1))
                text_q.push_back(8'("0" + $urandom_range(9)));
        end
        else if (sel == 18)
        begin
            text_q.push_back("0");
            text_q.push_back("x");
        end
        else
        begin
            // may wrap past 32 bits
            text_q.push_back(8'("1" + $urandom_range(8)));
            repeat ($urandom_range(12, 9))
                text_q.push_back(8'("0" + $urandom_range(9)));
        end
    endtask

    task automatic gen_string();
        int kind;
        int nparts;
        int pos;
        kind = $urandom_range(99);
        text_q.delete();
        if (kind < 8)
        begin
            repeat ($urandom_range(6))
                text_q.push_back(8'($urandom_range(255, 1)));
        end
        else
        begin
            nparts = ($urandom_range(19) == 0) ? 5 : $urandom_range(4, 1);
            for (int i = 0; i < nparts; i++)
            begin
                if (i != 0)
                    text_q.push_back(".");
                put_part(pick_value(i == nparts - 1, nparts));
            end
            if ($urandom_range(4) == 0)
            begin
                text_q.push_back($urandom_range(1) ? " " : 8'($urandom_range(13, 9)));
                repeat ($urandom_range(3))
                    text_q.push_back(8'($urandom_range(255, 1)));
            end
            if (kind < 22 && text_q.size() > 0)
            begin
                pos = $urandom_range(text_q.size() - 1);
                case ($urandom_range(2))
                    0: text_q.delete(pos);
                    1: text_q.insert(pos, 8'($urandom_range(255, 1)));
                    default: text_q[pos] = 8'($urandom_range(255, 1));
                endcase
            end
        end
        text_q.push_back(8'h00);
    endtask

    task automatic send_random(int target);
        while (sent_chars < target)
        begin
            gen_string();
            send_queued();
        end
    endtask

    initial
    begin
        string s;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 57;
        send_text("1.1.1.1.");
        send_text("");
        send_text("0x");
        send_text("09");
        send_text(".");
        s = "y";
        s[0] = 8'hff;
        send_text(s);
        s = "1 y";
        s[2] = 8'h80;
        send_text(s);

        send_random(533);
        drain_results();
        send_idle_pct = 57;
        recv_idle_pct = 28;
        send_random(1066);
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(1600);

        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (sb.due_count() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.due_count());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/ipv4tp_pkg.sv
src/ipv4tp_front.sv
src/ipv4tp_queue.sv
src/ipv4tp_back.sv
src/ipv4_text_address_parser.sv
tb/ipv4_text_address_parser_test.sv
